FILE: rtl/core/p2bfa_pkg.sv
// Shared types and constants for the power-of-two best-fit range allocator.
// Used by p2bfa_pool and pow2_best_fit_range_allocator; depends on nothing.
package p2bfa_pkg;

  localparam int MAX_CHUNKS     = 256;
  localparam int FREE_SLOTS     = 64;
  localparam int VERTEX_SEGMENT = 65536;
  localparam int INDEX_SEGMENT  = 65536;
  localparam int MAX_SEGMENTS   = 16;

  localparam int CHUNK_W = $clog2(MAX_CHUNKS);
  localparam int SLOT_W  = $clog2(FREE_SLOTS);
  localparam int CNT_W   = $clog2(FREE_SLOTS + 2);
  localparam int SEGS_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int COUNT_W = 16;
  localparam int START_W = 20;
  localparam int SIZE_W  = 17;
  localparam int CUR_W   = SIZE_W + 1;
  localparam int BASE_W  = SEGS_W + SIZE_W;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_SEGS = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PS_INIT, PS_IDLE, PS_RND, PS_HCHK, PS_SCAN, PS_HCMP, PS_PDEC,
    PS_PCNT, PS_CHELD, PS_CSHIFT, PS_CPIECE, PS_CFIN
  } pool_state_t;

  typedef enum logic [2:0] {
    TS_IDLE, TS_PV, TS_PI, TS_CV, TS_CI, TS_OUT
  } top_state_t;

  typedef struct packed {
    logic plan;
    logic commit;
  } pool_cmd_t;

  typedef struct packed {
    logic                done;
    status_t             status;
    logic [START_W-1:0]  start;
    logic [SIZE_W-1:0]   cap;
    logic                reused;
    logic                grew;
  } pool_res_t;

endpackage

FILE: rtl/core/pow2_best_fit_range_allocator.sv
// Top level of the power-of-two best-fit range allocator: request sequencing
// over a vertex pool and an index pool, and the result register. Uses p2bfa_pkg, p2bfa_pool.
//
// A request ends early when the vertex pool fails its plan. Otherwise each pool rounds
// its count up one doubling per cycle, scans its free list one entry per cycle through
// the compare unit, counts the split pieces one per cycle, and on commit shifts the
// list down and writes the pieces one entry per cycle through a single memory port.
// A full free list holds 64 entries. Only one request is in flight; a finished
// result waits in the output register while the next request is taken. After reset
// each pool seeds its free list in its init state before it is ready.
module pow2_best_fit_range_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [p2bfa_pkg::CHUNK_W-1:0] in_chunk_id,
  input  logic [p2bfa_pkg::COUNT_W-1:0] in_vertex_count,
  input  logic [p2bfa_pkg::COUNT_W-1:0] in_index_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [p2bfa_pkg::START_W-1:0] out_vertex_start,
  output logic [p2bfa_pkg::SIZE_W-1:0]  out_vertex_capacity,
  output logic [p2bfa_pkg::START_W-1:0] out_index_start,
  output logic [p2bfa_pkg::SIZE_W-1:0]  out_index_capacity,
  output logic                          out_vertex_reused,
  output logic                          out_index_reused,
  output logic                          out_vertex_grew,
  output logic                          out_index_grew,
  output logic [1:0]                    out_status
);

  p2bfa_pkg::top_state_t st_r, st_nxt;
  p2bfa_pkg::pool_cmd_t  vcmd, icmd;
  p2bfa_pkg::pool_res_t  vres, ires;
  p2bfa_pkg::status_t    err_r;
  logic vready, iready, in_acc, load, out_valid_r;
  logic [p2bfa_pkg::CHUNK_W-1:0] id_r;
  logic [p2bfa_pkg::COUNT_W-1:0] icount_r;

  logic [p2bfa_pkg::START_W-1:0] vs_r, is_r;
  logic [p2bfa_pkg::SIZE_W-1:0]  vc_r, ic_r;
  logic vru_r, iru_r, vgr_r, igr_r;
  logic [1:0] stat_r;

  assign in_ready = (st_r == p2bfa_pkg::TS_IDLE) && vready && iready;
  assign in_acc   = in_valid && in_ready;
  assign load     = (st_r == p2bfa_pkg::TS_OUT) && (!out_valid_r || out_ready);

  p2bfa_pool u_vpool (
    .clk      (clk),
    .rst_n    (rst_n),
    .seg_size (p2bfa_pkg::SIZE_W'(p2bfa_pkg::VERTEX_SEGMENT)),
    .cmd      (vcmd),
    .chunk_id (in_chunk_id),
    .count    (in_vertex_count),
    .ready    (vready),
    .res      (vres)
  );

  p2bfa_pool u_ipool (
    .clk      (clk),
    .rst_n    (rst_n),
    .seg_size (p2bfa_pkg::SIZE_W'(p2bfa_pkg::INDEX_SEGMENT)),
    .cmd      (icmd),
    .chunk_id (id_r),
    .count    (icount_r),
    .ready    (iready),
    .res      (ires)
  );

  // Request sequencer: plan vertex, plan index, then commit both; a failed plan skips to the output.
  always_comb begin
    st_nxt      = st_r;
    vcmd.plan   = 1'b0;
    vcmd.commit = 1'b0;
    icmd.plan   = 1'b0;
    icmd.commit = 1'b0;
    case (st_r)
      p2bfa_pkg::TS_IDLE: begin
        if (in_acc) begin
          vcmd.plan = 1'b1;
          st_nxt    = p2bfa_pkg::TS_PV;
        end
      end
      p2bfa_pkg::TS_PV: begin
        if (vres.done) begin
          if (vres.status != p2bfa_pkg::ST_OK) begin
            st_nxt = p2bfa_pkg::TS_OUT;
          end else begin
            icmd.plan = 1'b1;
            st_nxt    = p2bfa_pkg::TS_PI;
          end
        end
      end
      p2bfa_pkg::TS_PI: begin
        if (ires.done) begin
          if (ires.status != p2bfa_pkg::ST_OK) begin
            st_nxt = p2bfa_pkg::TS_OUT;
          end else begin
            vcmd.commit = 1'b1;
            st_nxt      = p2bfa_pkg::TS_CV;
          end
        end
      end
      p2bfa_pkg::TS_CV: begin
        if (vres.done) begin
          icmd.commit = 1'b1;
          st_nxt      = p2bfa_pkg::TS_CI;
        end
      end
      p2bfa_pkg::TS_CI: begin
        if (ires.done) st_nxt = p2bfa_pkg::TS_OUT;
      end
      p2bfa_pkg::TS_OUT: begin
        if (load) st_nxt = p2bfa_pkg::TS_IDLE;
      end
      default: st_nxt = p2bfa_pkg::TS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= p2bfa_pkg::TS_IDLE;
      out_valid_r <= 1'b0;
      err_r       <= p2bfa_pkg::ST_OK;
    end else begin
      st_r <= st_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (in_acc) err_r <= p2bfa_pkg::ST_OK;
      else if (st_r == p2bfa_pkg::TS_PV && vres.done) err_r <= vres.status;
      else if (st_r == p2bfa_pkg::TS_PI && ires.done) err_r <= ires.status;
    end
  end

  // Request fields held for the index pool, and the result register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      id_r     <= in_chunk_id;
      icount_r <= in_index_count;
    end
    if (load) begin
      if (err_r != p2bfa_pkg::ST_OK) begin
        vs_r  <= '0; vc_r  <= '0; is_r  <= '0; ic_r  <= '0;
        vru_r <= 1'b0; iru_r <= 1'b0; vgr_r <= 1'b0; igr_r <= 1'b0;
      end else begin
        vs_r  <= vres.start;  vc_r  <= vres.cap;
        is_r  <= ires.start;  ic_r  <= ires.cap;
        vru_r <= vres.reused; iru_r <= ires.reused;
        vgr_r <= vres.grew;   igr_r <= ires.grew;
      end
      stat_r <= err_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_vertex_start    = vs_r;
  assign out_vertex_capacity = vc_r;
  assign out_index_start     = is_r;
  assign out_index_capacity  = ic_r;
  assign out_vertex_reused   = vru_r;
  assign out_index_reused    = iru_r;
  assign out_vertex_grew     = vgr_r;
  assign out_index_grew      = igr_r;
  assign out_status          = stat_r;

endmodule

FILE: rtl/core/p2bfa_pool.sv
// One pool of the allocator: free list memory, per-chunk held ranges and a
// plan/commit sequencer around one shared compare unit. Depends on p2bfa_pkg.
module p2bfa_pool (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [p2bfa_pkg::SIZE_W-1:0]  seg_size,
  input  p2bfa_pkg::pool_cmd_t          cmd,
  input  logic [p2bfa_pkg::CHUNK_W-1:0] chunk_id,
  input  logic [p2bfa_pkg::COUNT_W-1:0] count,
  output logic                          ready,
  output p2bfa_pkg::pool_res_t          res
);

  p2bfa_pkg::pool_state_t st_r, st_nxt;

  // Free list and held-range memories.
  logic [p2bfa_pkg::START_W-1:0] fstart_mem [p2bfa_pkg::FREE_SLOTS];
  logic [p2bfa_pkg::SIZE_W-1:0]  fsize_mem  [p2bfa_pkg::FREE_SLOTS];
  logic [p2bfa_pkg::START_W-1:0] hstart_mem [p2bfa_pkg::MAX_CHUNKS];
  logic [p2bfa_pkg::SIZE_W-1:0]  hsize_mem  [p2bfa_pkg::MAX_CHUNKS];
  logic [p2bfa_pkg::MAX_CHUNKS-1:0] hvalid_r;

  logic [p2bfa_pkg::START_W-1:0] f_rs_r, h_rs_r, gstart_r, pick_s_r, pstart_r;
  logic [p2bfa_pkg::SIZE_W-1:0]  f_rz_r, h_rz_r, cap_r, pick_z_r, req_r, rem_r, rem0_r;
  logic [p2bfa_pkg::CUR_W-1:0]   cur_r;
  logic [p2bfa_pkg::CHUNK_W-1:0] id_r;
  logic [p2bfa_pkg::COUNT_W-1:0] cnt_in_r;
  logic [p2bfa_pkg::CNT_W-1:0]   used_r, scan_r, cidx_r, pick_r, ntot_r, ncut_r, cnt_r;
  logic [p2bfa_pkg::SLOT_W-1:0]  wa_r;
  logic [p2bfa_pkg::SEGS_W-1:0]  segs_r;
  logic reuse_r, happ_r, exact_r, found_r, grew_r, cv_r, wv_r, done_r;
  p2bfa_pkg::status_t status_r;

  logic [p2bfa_pkg::SLOT_W-1:0]  rd_a, wa;
  logic                          we;
  logic [p2bfa_pkg::START_W-1:0] wd_s;
  logic [p2bfa_pkg::SIZE_W-1:0]  wd_z, piece, cmp_sz;
  logic [p2bfa_pkg::START_W-1:0] cmp_s;
  logic [p2bfa_pkg::CNT_W-1:0]   cmp_idx;
  logic                          cmp_en, take, hv;
  logic [p2bfa_pkg::BASE_W-1:0]  base;

  assign hv    = hvalid_r[id_r];
  assign piece = (cur_r <= {1'b0, rem_r}) ? cur_r[p2bfa_pkg::SIZE_W-1:0] : rem_r;
  assign base  = p2bfa_pkg::BASE_W'(segs_r) * p2bfa_pkg::BASE_W'(seg_size);
  assign ready = (st_r == p2bfa_pkg::PS_IDLE);

  // Shared compare unit: memory entries during the scan, then the held range.
  always_comb begin
    cmp_en  = (st_r == p2bfa_pkg::PS_SCAN && cv_r) || (st_r == p2bfa_pkg::PS_HCMP && happ_r);
    cmp_sz  = (st_r == p2bfa_pkg::PS_HCMP) ? h_rz_r : f_rz_r;
    cmp_s   = (st_r == p2bfa_pkg::PS_HCMP) ? h_rs_r : f_rs_r;
    cmp_idx = (st_r == p2bfa_pkg::PS_HCMP) ? used_r : cidx_r;
    take    = cmp_en && !exact_r &&
              (cmp_sz == req_r || (cmp_sz > req_r && (!found_r || cmp_sz < pick_z_r)));
  end

  // Free list port selection.
  always_comb begin
    rd_a = scan_r[p2bfa_pkg::SLOT_W-1:0];
    we   = 1'b0;
    wa   = '0;
    wd_s = '0;
    wd_z = seg_size;
    case (st_r)
      p2bfa_pkg::PS_INIT: begin
        we = 1'b1;
      end
      p2bfa_pkg::PS_CHELD: begin
        we   = happ_r;
        wa   = used_r[p2bfa_pkg::SLOT_W-1:0];
        wd_s = h_rs_r;
        wd_z = h_rz_r;
      end
      p2bfa_pkg::PS_CSHIFT: begin
        we   = wv_r;
        wa   = wa_r;
        wd_s = f_rs_r;
        wd_z = f_rz_r;
      end
      p2bfa_pkg::PS_CPIECE: begin
        we   = (rem_r != '0);
        wa   = cnt_r[p2bfa_pkg::SLOT_W-1:0];
        wd_s = pstart_r;
        wd_z = piece;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      fstart_mem[wa] <= wd_s;
      fsize_mem[wa]  <= wd_z;
    end
    f_rs_r <= fstart_mem[rd_a];
    f_rz_r <= fsize_mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (st_r == p2bfa_pkg::PS_CFIN) begin
      hstart_mem[id_r] <= gstart_r;
      hsize_mem[id_r]  <= cap_r;
    end
    h_rs_r <= hstart_mem[id_r];
    h_rz_r <= hsize_mem[id_r];
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      p2bfa_pkg::PS_INIT: st_nxt = p2bfa_pkg::PS_IDLE;
      p2bfa_pkg::PS_IDLE: begin
        if (cmd.plan) st_nxt = p2bfa_pkg::PS_RND;
        else if (cmd.commit && !reuse_r) st_nxt = p2bfa_pkg::PS_CHELD;
      end
      p2bfa_pkg::PS_RND: begin
        if (!(req_r < {1'b0, cnt_in_r})) st_nxt = p2bfa_pkg::PS_HCHK;
      end
      p2bfa_pkg::PS_HCHK: begin
        if (hv && (h_rz_r >= req_r || used_r >= p2bfa_pkg::CNT_W'(p2bfa_pkg::FREE_SLOTS)))
          st_nxt = p2bfa_pkg::PS_IDLE;
        else
          st_nxt = p2bfa_pkg::PS_SCAN;
      end
      p2bfa_pkg::PS_SCAN: begin
        if (!(scan_r < used_r) && !cv_r) st_nxt = p2bfa_pkg::PS_HCMP;
      end
      p2bfa_pkg::PS_HCMP: st_nxt = p2bfa_pkg::PS_PDEC;
      p2bfa_pkg::PS_PDEC: begin
        if ((found_r && exact_r) ||
            (!found_r && segs_r >= p2bfa_pkg::SEGS_W'(p2bfa_pkg::MAX_SEGMENTS)))
          st_nxt = p2bfa_pkg::PS_IDLE;
        else
          st_nxt = p2bfa_pkg::PS_PCNT;
      end
      p2bfa_pkg::PS_PCNT: begin
        if (rem_r == '0 || cnt_r >= p2bfa_pkg::CNT_W'(p2bfa_pkg::FREE_SLOTS))
          st_nxt = p2bfa_pkg::PS_IDLE;
      end
      p2bfa_pkg::PS_CHELD: begin
        st_nxt = found_r ? p2bfa_pkg::PS_CSHIFT : p2bfa_pkg::PS_CPIECE;
      end
      p2bfa_pkg::PS_CSHIFT: begin
        if (!(scan_r < ntot_r) && !wv_r) st_nxt = p2bfa_pkg::PS_CPIECE;
      end
      p2bfa_pkg::PS_CPIECE: begin
        if (rem_r == '0) st_nxt = p2bfa_pkg::PS_CFIN;
      end
      p2bfa_pkg::PS_CFIN: st_nxt = p2bfa_pkg::PS_IDLE;
      default: st_nxt = p2bfa_pkg::PS_INIT;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= p2bfa_pkg::PS_INIT;
      hvalid_r <= '0;
      used_r   <= p2bfa_pkg::CNT_W'(1);
      segs_r   <= p2bfa_pkg::SEGS_W'(1);
      done_r   <= 1'b0;
      reuse_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= 1'b0;
      case (st_r)
        p2bfa_pkg::PS_IDLE: begin
          if (cmd.plan) reuse_r <= 1'b0;
          else if (cmd.commit && reuse_r) done_r <= 1'b1;
        end
        p2bfa_pkg::PS_HCHK: begin
          if (hv && h_rz_r >= req_r) begin
            reuse_r <= 1'b1;
            done_r  <= 1'b1;
          end else if (hv && used_r >= p2bfa_pkg::CNT_W'(p2bfa_pkg::FREE_SLOTS)) begin
            done_r <= 1'b1;
          end
        end
        p2bfa_pkg::PS_PDEC: begin
          if ((found_r && exact_r) ||
              (!found_r && segs_r >= p2bfa_pkg::SEGS_W'(p2bfa_pkg::MAX_SEGMENTS)))
            done_r <= 1'b1;
        end
        p2bfa_pkg::PS_PCNT: begin
          if (rem_r == '0 || cnt_r >= p2bfa_pkg::CNT_W'(p2bfa_pkg::FREE_SLOTS))
            done_r <= 1'b1;
        end
        p2bfa_pkg::PS_CFIN: begin
          used_r           <= cnt_r;
          hvalid_r[id_r]   <= 1'b1;
          segs_r           <= segs_r + p2bfa_pkg::SEGS_W'(grew_r);
          done_r           <= 1'b1;
        end
        default: begin
          done_r <= 1'b0;
        end
      endcase
    end
  end

  // Datapath of the sequencer.
  always_ff @(posedge clk) begin
    if (take) begin
      found_r  <= 1'b1;
      exact_r  <= (cmp_sz == req_r);
      pick_r   <= cmp_idx;
      pick_s_r <= cmp_s;
      pick_z_r <= cmp_sz;
    end
    case (st_r)
      p2bfa_pkg::PS_IDLE: begin
        if (cmd.plan) begin
          id_r     <= chunk_id;
          cnt_in_r <= count;
          req_r    <= p2bfa_pkg::SIZE_W'(1);
        end
      end
      p2bfa_pkg::PS_RND: begin
        if (req_r < {1'b0, cnt_in_r}) req_r <= req_r << 1;
      end
      p2bfa_pkg::PS_HCHK: begin
        found_r  <= 1'b0;
        exact_r  <= 1'b0;
        grew_r   <= 1'b0;
        happ_r   <= hv;
        scan_r   <= '0;
        cv_r     <= 1'b0;
        ntot_r   <= used_r + p2bfa_pkg::CNT_W'(hv);
        gstart_r <= h_rs_r;
        cap_r    <= h_rz_r;
        status_r <= (hv && h_rz_r < req_r) ? p2bfa_pkg::ST_FULL : p2bfa_pkg::ST_OK;
      end
      p2bfa_pkg::PS_SCAN: begin
        if (scan_r < used_r) begin
          scan_r <= scan_r + p2bfa_pkg::CNT_W'(1);
          cidx_r <= scan_r;
          cv_r   <= 1'b1;
        end else begin
          cv_r <= 1'b0;
        end
      end
      p2bfa_pkg::PS_PDEC: begin
        cap_r    <= req_r;
        cur_r    <= p2bfa_pkg::CUR_W'(req_r);
        status_r <= p2bfa_pkg::ST_OK;
        if (found_r) begin
          gstart_r <= pick_s_r;
          rem_r    <= pick_z_r - req_r;
          rem0_r   <= pick_z_r - req_r;
          cnt_r    <= ntot_r - p2bfa_pkg::CNT_W'(1);
          ncut_r   <= ntot_r - p2bfa_pkg::CNT_W'(1);
        end else begin
          if (segs_r >= p2bfa_pkg::SEGS_W'(p2bfa_pkg::MAX_SEGMENTS))
            status_r <= p2bfa_pkg::ST_SEGS;
          grew_r   <= 1'b1;
          gstart_r <= base[p2bfa_pkg::START_W-1:0];
          rem_r    <= seg_size - req_r;
          rem0_r   <= seg_size - req_r;
          cnt_r    <= ntot_r;
          ncut_r   <= ntot_r;
        end
      end
      p2bfa_pkg::PS_PCNT: begin
        if (rem_r != '0) begin
          if (cnt_r >= p2bfa_pkg::CNT_W'(p2bfa_pkg::FREE_SLOTS)) begin
            status_r <= p2bfa_pkg::ST_FULL;
          end else begin
            rem_r <= rem_r - piece;
            cnt_r <= cnt_r + p2bfa_pkg::CNT_W'(1);
            cur_r <= cur_r << 1;
          end
        end
      end
      p2bfa_pkg::PS_CHELD: begin
        scan_r   <= pick_r + p2bfa_pkg::CNT_W'(1);
        wv_r     <= 1'b0;
        rem_r    <= rem0_r;
        cur_r    <= p2bfa_pkg::CUR_W'(req_r);
        cnt_r    <= ncut_r;
        pstart_r <= gstart_r + p2bfa_pkg::START_W'(req_r);
      end
      p2bfa_pkg::PS_CSHIFT: begin
        if (scan_r < ntot_r) begin
          scan_r <= scan_r + p2bfa_pkg::CNT_W'(1);
          wa_r   <= p2bfa_pkg::SLOT_W'(scan_r - p2bfa_pkg::CNT_W'(1));
          wv_r   <= 1'b1;
        end else begin
          wv_r <= 1'b0;
        end
      end
      p2bfa_pkg::PS_CPIECE: begin
        if (rem_r != '0) begin
          rem_r    <= rem_r - piece;
          cnt_r    <= cnt_r + p2bfa_pkg::CNT_W'(1);
          cur_r    <= cur_r << 1;
          pstart_r <= pstart_r + p2bfa_pkg::START_W'(piece);
        end
      end
      default: begin
        wv_r <= wv_r;
      end
    endcase
  end

  assign res.done   = done_r;
  assign res.status = status_r;
  assign res.start  = gstart_r;
  assign res.cap    = cap_r;
  assign res.reused = reuse_r;
  assign res.grew   = grew_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= p2bfa_pkg::CNT_W'(p2bfa_pkg::FREE_SLOTS))
    else $error("free list count past its depth");
  a_segs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    segs_r <= p2bfa_pkg::SEGS_W'(p2bfa_pkg::MAX_SEGMENTS))
    else $error("pool segment count past its limit");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("done held longer than one cycle");
  a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.plan || cmd.commit) |-> ready)
    else $error("command issued while the pool is busy");
`endif

endmodule
